// ===== rtl/stbs_pkg.sv =====
package stbs_pkg;

  // item field widths
  localparam int MODE_W  = 3;
  localparam int INDEX_W = 10;
  localparam int KEY_W   = 32;
  localparam int COUNT_W = 11;
  localparam int POS_W   = 10;

  // operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // search modes
  localparam logic [MODE_W-1:0] MODE_ANY_EQ   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FIRST_EQ = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LAST_EQ  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIRST_GE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LAST_LE  = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic latch;
    logic cfg_wr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
  } status_t;

endpackage

// ===== rtl/stbs_ifs.sv =====
interface stbs_req_if;
  import stbs_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [MODE_W-1:0]         search_mode;
  logic [INDEX_W-1:0]        entry_index;
  logic signed [KEY_W-1:0]   key_value;
  modport source (output valid, output operation, output search_mode,
                  output entry_index, output key_value, input ready);
  modport sink (input valid, input operation, input search_mode,
                input entry_index, input key_value, output ready);
endinterface

interface stbs_rsp_if;
  import stbs_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;
  modport source (output valid, output found, output position, input ready);
  modport sink (input valid, input found, input position, output ready);
endinterface

interface stbs_cfg_if;
  import stbs_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/stbs_ram.sv =====
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/stbs_ctrl.sv =====
module stbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  output stbs_pkg::cmd_t   cmd,
  input  stbs_pkg::status_t st
);
  import stbs_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic accept;
  logic out_free;

  // handshakes and commands
  always_comb begin
    in_ready   = (state == ST_IDLE);
    cfg_ready  = 1'b1;
    accept     = in_valid & in_ready;
    out_free   = ~out_valid | out_ready;
    cmd.load   = accept & (in_op == OP_LOAD);
    cmd.start  = accept & (in_op == OP_SEARCH);
    cmd.step   = (state == ST_BUSY) & ~st.done;
    cmd.latch  = (state == ST_BUSY) & st.done & out_free;
    cmd.cfg_wr = cfg_valid;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.start) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (cmd.latch) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output slot
  always_comb begin
    if (cmd.latch) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid & ~out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/stbs_dp.sv =====
module stbs_dp #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  stbs_pkg::cmd_t                 cmd,
  output stbs_pkg::status_t              st,
  input  logic [stbs_pkg::MODE_W-1:0]    in_mode,
  input  logic [stbs_pkg::INDEX_W-1:0]   in_index,
  input  logic signed [stbs_pkg::KEY_W-1:0] in_key,
  input  logic [stbs_pkg::COUNT_W-1:0]   cfg_data,
  output logic                           res_found,
  output logic [stbs_pkg::POS_W-1:0]     res_position
);
  import stbs_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [COUNT_W-1:0]   entry_count;
  logic [KEY_WIDTH-1:0] key_in;
  logic [KEY_WIDTH-1:0] key_r;
  logic [MODE_W-1:0]    mode_r;
  logic [MODE_W-1:0]    mode_sel;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     n_start;
  logic [CNT_W-1:0]     low;
  logic [CNT_W-1:0]     hi;
  logic [CNT_W-1:0]     low_next;
  logic [CNT_W-1:0]     hi_next;
  logic [CNT_W-1:0]     low_upd;
  logic [CNT_W-1:0]     hi_upd;
  logic [CNT_W-1:0]     mid_cur;
  logic [CNT_W-1:0]     mid_next;
  logic [IDX_W-1:0]     nbr_addr;
  logic [KEY_WIDTH-1:0] rd_mid;
  logic [KEY_WIDTH-1:0] rd_nbr;
  logic                 load_we;
  logic                 hit;
  logic                 bad_mode;
  logic                 win_empty;
  logic                 upd_empty;
  logic                 at_first;
  logic                 at_last;
  logic                 e_eq;
  logic                 e_gt;
  logic                 e_lt;
  logic                 nbr_eq;
  logic                 nbr_lt;
  logic                 nbr_gt;

  // key taken from the low bits of the input, zero-extended when the table is wider
  generate
    if (KEY_WIDTH <= KEY_W) begin : g_key_narrow
      assign key_in = in_key[KEY_WIDTH-1:0];
    end else begin : g_key_wide
      assign key_in = {{(KEY_WIDTH-KEY_W){1'b0}}, in_key};
    end
  endgenerate

  // count register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.cfg_wr) begin
      entry_count <= cfg_data;
    end
  end

  // window size clamped to the table depth
  assign n_start = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                        : CNT_W'(entry_count);

  // midpoint of the window in flight
  assign mid_cur   = low + ((hi - low - CNT_W'(1)) >> 1);
  assign win_empty = (low >= hi);
  assign at_first  = (mid_cur == '0);
  assign at_last   = ((mid_cur + CNT_W'(1)) == n_r);

  // signed compares against the probed entry and its neighbor
  assign e_eq   = (rd_mid == key_r);
  assign e_gt   = ($signed(rd_mid) > $signed(key_r));
  assign e_lt   = ($signed(rd_mid) < $signed(key_r));
  assign nbr_eq = (rd_nbr == key_r);
  assign nbr_lt = ($signed(rd_nbr) < $signed(key_r));
  assign nbr_gt = ($signed(rd_nbr) > $signed(key_r));

  // probe decision per mode
  always_comb begin
    low_upd  = low;
    hi_upd   = hi;
    hit      = 1'b0;
    bad_mode = 1'b0;
    case (mode_r)
      MODE_ANY_EQ: begin
        if (e_eq) begin
          hit = 1'b1;
        end else if (e_gt) begin
          hi_upd = mid_cur;
        end else begin
          low_upd = mid_cur + CNT_W'(1);
        end
      end
      MODE_FIRST_EQ: begin
        if (e_gt) begin
          hi_upd = mid_cur;
        end else if (e_lt) begin
          low_upd = mid_cur + CNT_W'(1);
        end else if (at_first || !nbr_eq) begin
          hit = 1'b1;
        end else begin
          hi_upd = mid_cur;
        end
      end
      MODE_LAST_EQ: begin
        if (e_gt) begin
          hi_upd = mid_cur;
        end else if (e_lt) begin
          low_upd = mid_cur + CNT_W'(1);
        end else if (at_last || !nbr_eq) begin
          hit = 1'b1;
        end else begin
          low_upd = mid_cur + CNT_W'(1);
        end
      end
      MODE_FIRST_GE: begin
        if (!e_lt) begin
          if (at_first || nbr_lt) begin
            hit = 1'b1;
          end else begin
            hi_upd = mid_cur;
          end
        end else begin
          low_upd = mid_cur + CNT_W'(1);
        end
      end
      MODE_LAST_LE: begin
        if (!e_gt) begin
          if (at_last || nbr_gt) begin
            hit = 1'b1;
          end else begin
            low_upd = mid_cur + CNT_W'(1);
          end
        end else begin
          hi_upd = mid_cur;
        end
      end
      default: bad_mode = 1'b1;
    endcase
  end

  assign upd_empty = (low_upd >= hi_upd);
  assign st.done   = bad_mode | win_empty | hit | upd_empty;

  // window for the next probe
  always_comb begin
    if (cmd.start) begin
      low_next = '0;
      hi_next  = n_start;
      mode_sel = in_mode;
    end else if (cmd.step) begin
      low_next = low_upd;
      hi_next  = hi_upd;
      mode_sel = mode_r;
    end else begin
      low_next = low;
      hi_next  = hi;
      mode_sel = mode_r;
    end
  end

  assign mid_next = low_next + ((hi_next - low_next - CNT_W'(1)) >> 1);

  // neighbor below for first-style searches, above for last-style
  always_comb begin
    if (mode_sel == MODE_FIRST_EQ || mode_sel == MODE_FIRST_GE) begin
      nbr_addr = IDX_W'(mid_next - CNT_W'(1));
    end else begin
      nbr_addr = IDX_W'(mid_next + CNT_W'(1));
    end
  end

  // search registers
  always_ff @(posedge clk) begin
    low <= low_next;
    hi  <= hi_next;
    if (cmd.start) begin
      key_r  <= key_in;
      mode_r <= in_mode;
      n_r    <= n_start;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      res_found <= hit & ~bad_mode & ~win_empty;
      if (hit && !bad_mode && !win_empty) begin
        res_position <= POS_W'(mid_cur);
      end else begin
        res_position <= '0;
      end
    end
  end

  // table storage
  assign load_we = cmd.load & (32'(in_index) < 32'(TABLE_DEPTH));

  stbs_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (load_we),
    .waddr   (IDX_W'(in_index)),
    .wdata   (key_in),
    .raddr_a (IDX_W'(mid_next)),
    .rdata_a (rd_mid),
    .raddr_b (nbr_addr),
    .rdata_b (rd_nbr)
  );

endmodule

// ===== rtl/sorted_table_binary_search_core.sv =====
// Load item: taken while no search is in progress, one load per cycle back to back, no result.
// Search item: one table probe per cycle, up to floor(log2(n)) + 1 probes over n entries
// (11 for 1024); the last probe registers the result and the output slot, and the core
// turns idle with it, so the result turns valid as the next item can be taken; the last
// probe is held only while an earlier result still waits on the output.
// Reset (synchronous, active high) clears controller, output slot and count, not the table.
module sorted_table_binary_search_core #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input logic         clk,
  input logic         rst,
  stbs_req_if.sink    req,
  stbs_rsp_if.source  rsp,
  stbs_cfg_if.sink    cfg
);
  import stbs_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencing
  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_op     (req.operation),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cmd       (cmd),
    .st        (st)
  );

  // table, window and compare
  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .in_mode      (req.search_mode),
    .in_index     (req.entry_index),
    .in_key       (req.key_value),
    .cfg_data     (cfg.data),
    .res_found    (rsp.found),
    .res_position (rsp.position)
  );

  // a load never produces a result
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.operation == OP_LOAD) |=> !$rose(rsp.valid))
    else $error("result raised after a load item");

  // a miss reports position zero
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.position == '0))
    else $error("miss with nonzero position");

  // a search occupies the block for at least one probe
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.operation == OP_SEARCH) |=> !req.ready)
    else $error("input ready right after a search item");

endmodule

// ===== bench/stbs_search_board_pkg.sv =====
`timescale 1ns / 1ps
package stbs_search_board_pkg;
  import stbs_pkg::*;

  localparam int TABLE_SIZE   = 1024;
  localparam int REPORT_LIMIT = 10;

  // one search answer
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } lookup_t;

  class bound_search_board;
    logic signed [KEY_W-1:0] entries [TABLE_SIZE];
    logic [COUNT_W-1:0]      entry_count;
    lookup_t                 awaited_answers [$];
    int                      failures;

    function new();
      entry_count = '0;
      failures = 0;
    endfunction

    function void write_count(logic [COUNT_W-1:0] value);
      entry_count = value;
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= REPORT_LIMIT) begin
        $display("mismatch: %s", what);
      end
    endfunction

    function lookup_t hit(int at);
      lookup_t answer;
      answer.found = 1'b1;
      answer.position = POS_W'(at);
      return answer;
    endfunction

    // midpoint halving over entries 0 .. n-1, count saturated at the depth
    function lookup_t locate_key(logic [MODE_W-1:0] mode, logic signed [KEY_W-1:0] key);
      int n;
      int lo;
      int hi;
      int mid;
      logic signed [KEY_W-1:0] probe;
      lookup_t miss;
      miss = '0;
      n = (entry_count > TABLE_SIZE) ? TABLE_SIZE : int'(entry_count);
      if (mode > MODE_LAST_LE) return miss;
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
        mid = lo + ((hi - lo) >>> 1);
        probe = entries[mid];
        case (mode)
          MODE_ANY_EQ: begin
            if (probe == key) return hit(mid);
            if (probe > key) hi = mid - 1;
            else lo = mid + 1;
          end
          MODE_FIRST_EQ: begin
            if (probe > key) hi = mid - 1;
            else if (probe < key) lo = mid + 1;
            else if (mid == 0 || entries[mid-1] != key) return hit(mid);
            else hi = mid - 1;
          end
          MODE_LAST_EQ: begin
            if (probe > key) hi = mid - 1;
            else if (probe < key) lo = mid + 1;
            else if (mid == n - 1 || entries[mid+1] != key) return hit(mid);
            else lo = mid + 1;
          end
          MODE_FIRST_GE: begin
            if (probe >= key) begin
              if (mid == 0 || entries[mid-1] < key) return hit(mid);
              hi = mid - 1;
            end else begin
              lo = mid + 1;
            end
          end
          default: begin
            if (probe <= key) begin
              if (mid == n - 1 || entries[mid+1] > key) return hit(mid);
              lo = mid + 1;
            end else begin
              hi = mid - 1;
            end
          end
        endcase
      end
      return miss;
    endfunction

    // accepted input item: loads update the table, searches queue an answer
    function void note_item(logic op, logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                            logic signed [KEY_W-1:0] key);
      if (op == OP_LOAD) begin
        entries[idx] = key;
      end else begin
        awaited_answers.push_back(locate_key(mode, key));
      end
    endfunction

    function void check_answer(logic found, logic [POS_W-1:0] position);
      lookup_t want;
      if (awaited_answers.size() == 0) begin
        flag($sformatf("result found=%0b position=%0d with no search pending", found, position));
      end else begin
        want = awaited_answers.pop_front();
        if (found !== want.found) begin
          flag($sformatf("found expected %0b actual %0b", want.found, found));
        end
        if (position !== want.position) begin
          flag($sformatf("position expected %0d actual %0d", want.position, position));
        end
      end
    endfunction

    function void finish_check();
      if (awaited_answers.size() != 0) begin
        flag($sformatf("%0d searches never answered", awaited_answers.size()));
      end
    endfunction
  endclass

endpackage

// ===== bench/sorted_table_binary_search_core_tb.sv =====
`timescale 1ns / 1ps
module sorted_table_binary_search_core_tb;
  import stbs_pkg::*;
  import stbs_search_board_pkg::*;

  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TOTAL_ITEMS   = 1200;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
  localparam logic [COUNT_W-1:0] COUNT_ALL_ONES  = '1;

  logic clk = 1'b0;
  logic rst;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   items_sent;

  bound_search_board board = new();

  stbs_req_if req_ch ();
  stbs_rsp_if rsp_ch ();
  stbs_cfg_if cfg_ch ();

  sorted_table_binary_search_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #2 clk = ~clk;

  // result backpressure
  always @(negedge clk) begin
    rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // every accepted item and result goes to the board
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        board.note_item(req_ch.operation, req_ch.search_mode, req_ch.entry_index,
                        req_ch.key_value);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        board.check_answer(rsp_ch.found, rsp_ch.position);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        board.write_count(cfg_ch.data);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL sorted_table_binary_search_core");
    $finish;
  end

  // present one item and hold it until accepted
  task automatic send_item(input logic op, input logic [MODE_W-1:0] mode,
                           input logic [INDEX_W-1:0] idx, input logic signed [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      req_ch.key_value = $urandom;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.operation = op;
    req_ch.search_mode = mode;
    req_ch.entry_index = idx;
    req_ch.key_value = key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic load(input logic [INDEX_W-1:0] idx, input logic signed [KEY_W-1:0] key);
    send_item(OP_LOAD, MODE_W'($urandom_range(7)), idx, key);
  endtask

  task automatic search(input logic [MODE_W-1:0] mode, input logic signed [KEY_W-1:0] key);
    send_item(OP_SEARCH, mode, INDEX_W'($urandom_range(1023)), key);
  endtask

  task automatic drain_answers();
    req_ch.valid = 1'b0;
    while (board.awaited_answers.size() != 0) @(negedge clk);
  endtask

  // count register is only written with the core idle
  task automatic set_entry_count(input logic [COUNT_W-1:0] value);
    drain_answers();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    cfg_ch.data = COUNT_W'($urandom);
  endtask

  // load entries 0 .. n-1, normally ascending with duplicates
  task automatic fill_table(input int n, input bit scramble);
    int keys [$];
    int style;
    int base;
    style = $urandom_range(2);
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      case (style)
        0: keys.push_back($urandom);
        1: keys.push_back(base + int'($urandom_range(n)));
        default: keys.push_back(base + int'($urandom_range(3)));
      endcase
    end
    if (!scramble) begin
      keys.sort();
      if (n >= 2 && $urandom_range(1) == 1) begin
        keys[0] = KEY_MIN;
        keys[n-1] = KEY_MAX;
      end
    end
    if ($urandom_range(1) == 1) begin
      for (int i = 0; i < n; i++) load(INDEX_W'(i), keys[i]);
    end else begin
      for (int i = n - 1; i >= 0; i--) load(INDEX_W'(i), keys[i]);
    end
  endtask

  // searches over the first n entries, with rewrites and full drains mixed in
  task automatic search_burst(input int n, input int count);
    int pick;
    logic [MODE_W-1:0] mode;
    logic signed [KEY_W-1:0] key;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        drain_answers();
      end else if (pick < 9 && n > 0) begin
        load(INDEX_W'($urandom_range(n - 1)), $urandom);
      end else begin
        if ($urandom_range(99) < 8) begin
          mode = MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
        end else begin
          mode = MODE_W'($urandom_range(MODE_LAST_LE, MODE_ANY_EQ));
        end
        pick = $urandom_range(99);
        if (n > 0 && pick < 45) key = board.entries[$urandom_range(n - 1)];
        else if (n > 0 && pick < 70)
          key = board.entries[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1);
        else if (pick < 85) key = $urandom;
        else key = $urandom_range(1) ? KEY_MIN : KEY_MAX;
        search(mode, key);
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    int n;
    int pick;
    int stop_at;
    logic [COUNT_W-1:0] count_value;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_LOAD;
    req_ch.search_mode = MODE_ANY_EQ;
    req_ch.entry_index = '0;
    req_ch.key_value = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty table after reset: nothing is ever found
    search(MODE_ANY_EQ, 0);
    search(MODE_FIRST_EQ, KEY_MIN);
    search(MODE_LAST_EQ, KEY_MAX);
    search(MODE_FIRST_GE, KEY_MIN);
    search(MODE_LAST_LE, KEY_MAX);
    search(MODE_SPARE_FIRST, 0);
    search(MODE_SPARE_FIRST + 3'd1, -1);
    search(MODE_SPARE_LAST, KEY_MAX);

    // four entries with key extremes at the ends and a duplicate pair
    set_entry_count(COUNT_W'(4));
    load(INDEX_W'(0), KEY_MIN);
    load(INDEX_W'(1), 7);
    load(INDEX_W'(2), 7);
    load(INDEX_W'(3), KEY_MAX);
    search(MODE_ANY_EQ, 7);
    search(MODE_FIRST_EQ, 7);
    search(MODE_LAST_EQ, 7);
    search(MODE_FIRST_GE, 6);
    search(MODE_LAST_LE, 8);
    search(MODE_FIRST_GE, KEY_MAX);
    search(MODE_LAST_LE, KEY_MIN);
    search(MODE_ANY_EQ, 8);
    search(MODE_FIRST_EQ, KEY_MIN);
    search(MODE_LAST_EQ, KEY_MAX);
    search(MODE_SPARE_LAST, 7);

    // count above the depth saturates at the depth; the whole table gets loaded
    set_entry_count(COUNT_ALL_ONES);
    fill_table(TABLE_SIZE, 1'b0);
    search_burst(TABLE_SIZE, 60);
    set_entry_count(COUNT_W'(TABLE_SIZE));
    search_burst(TABLE_SIZE, 40);

    // random phases, rotating through every idle pattern at least once
    phase = 0;
    stop_at = TOTAL_ITEMS;
    while (items_sent < stop_at || phase < 4) begin
      drain_answers();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      pick = $urandom_range(99);
      if (pick < 8) count_value = '0;
      else if (pick < 14) count_value = COUNT_W'($urandom_range(2047, TABLE_SIZE + 1));
      else if (pick < 18) count_value = COUNT_W'(TABLE_SIZE);
      else if (pick < 28) count_value = COUNT_W'($urandom_range(300, 41));
      else count_value = COUNT_W'($urandom_range(40, 1));
      set_entry_count(count_value);
      n = (count_value > TABLE_SIZE) ? TABLE_SIZE : int'(count_value);
      // large tables keep their earlier contents
      if (n > 0 && n <= 300 && $urandom_range(99) < 80) begin
        fill_table(n, $urandom_range(99) < 15);
      end
      if (n < TABLE_SIZE) begin
        repeat ($urandom_range(3)) load(INDEX_W'($urandom_range(TABLE_SIZE - 1, n)), $urandom);
      end
      search_burst(n, $urandom_range(50, 15));
      phase++;
    end

    drain_answers();
    repeat (SETTLE_CYCLES) @(negedge clk);
    board.finish_check();
    if (board.failures == 0) begin
      $display("PASS sorted_table_binary_search_core");
    end else begin
      $display("FAIL sorted_table_binary_search_core");
    end
    $finish;
  end

endmodule
